/* src/msdb_pkg.sv */
`default_nettype none
package msdb_pkg;

    localparam int PIN_W       = 4;
    localparam int CHAN_W      = 2;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd30;

    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic [PIN_W-1:0]  pin_levels;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              new_level;
        logic [TIME_W-1:0] event_time;
        logic [PIN_W-1:0]  stable_inputs;
        logic              last_event;
    } t_out;

    // one poll that changed at least one stable bit
    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic [PIN_W-1:0]  old_stable;
        logic [PIN_W-1:0]  flips;
        logic [PIN_W-1:0]  levels;
    } t_run;

endpackage
`default_nettype wire

/* src/msdb_front.sv */
`default_nettype none
module msdb_front #(
    parameter int LANES = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  msdb_pkg::t_in             i_in_data,
    input  wire [msdb_pkg::DEB_W-1:0] i_debounce_time,
    output logic                      o_q_valid,
    input  wire                       i_q_ready,
    output msdb_pkg::t_run            o_q_data
);

    logic [msdb_pkg::PIN_W-1:0]  r_prev;
    logic [msdb_pkg::PIN_W-1:0]  n_prev;
    logic [msdb_pkg::PIN_W-1:0]  r_stable;
    logic [msdb_pkg::PIN_W-1:0]  n_stable;
    logic [msdb_pkg::TIME_W-1:0] r_ct [LANES];
    logic [msdb_pkg::TIME_W-1:0] n_ct [LANES];
    logic [msdb_pkg::PIN_W-1:0]  flips;
    logic                        accept;

    always_comb begin
        logic                        logical;
        logic [msdb_pkg::TIME_W-1:0] elapsed;
        n_prev = '0;
        flips  = '0;
        for (int i = 0; i < LANES; i++) begin
            logical   = ~i_in_data.pin_levels[i];
            n_prev[i] = logical;
            n_ct[i]   = (logical != r_prev[i]) ? i_in_data.now_time : r_ct[i];
            elapsed   = i_in_data.now_time - n_ct[i];
            flips[i]  = (elapsed >= {{(msdb_pkg::TIME_W-msdb_pkg::DEB_W){1'b0}},
                                     i_debounce_time}) && (logical != r_stable[i]);
        end
        n_stable = r_stable ^ flips;
    end

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid & i_q_ready;
    assign o_q_valid  = accept & (|flips);

    always_comb begin
        o_q_data.now_time   = i_in_data.now_time;
        o_q_data.old_stable = r_stable;
        o_q_data.flips      = flips;
        o_q_data.levels     = n_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_stable <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_ct[i] <= '0;
            end
        end else if (accept) begin
            r_prev   <= n_prev;
            r_stable <= n_stable;
            for (int i = 0; i < LANES; i++) begin
                r_ct[i] <= n_ct[i];
            end
        end
    end

endmodule
`default_nettype wire

/* src/msdb_fifo.sv */
`default_nettype none
module msdb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* src/msdb_back.sv */
`default_nettype none
module msdb_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_q_valid,
    output logic           o_q_ready,
    input  msdb_pkg::t_run i_q_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output msdb_pkg::t_out o_out_data
);

    logic [msdb_pkg::PIN_W-1:0]  r_done;
    logic [msdb_pkg::PIN_W-1:0]  n_done;
    logic [msdb_pkg::PIN_W-1:0]  pending;
    logic [msdb_pkg::PIN_W-1:0]  onehot;
    logic [msdb_pkg::CHAN_W-1:0] idx;
    logic                        last;
    logic                        can_load;
    logic                        issue;
    logic                        r_out_valid;
    msdb_pkg::t_out              r_out;
    msdb_pkg::t_out              n_out;

    always_comb begin
        pending = i_q_data.flips & ~r_done;
        idx     = '0;
        for (int i = msdb_pkg::PIN_W - 1; i >= 0; i--) begin
            if (pending[i]) begin
                idx = msdb_pkg::CHAN_W'(i);
            end
        end
        onehot = msdb_pkg::PIN_W'(1) << idx;
        last   = ((pending & ~onehot) == '0);
    end

    assign can_load  = ~r_out_valid | i_out_ready;
    assign issue     = i_q_valid & can_load;
    assign o_q_ready = issue & last;

    always_comb begin
        n_done = r_done;
        if (issue) begin
            n_done = last ? '0 : (r_done | onehot);
        end
        n_out.channel       = idx;
        n_out.new_level     = i_q_data.levels[idx];
        n_out.event_time    = i_q_data.now_time;
        n_out.stable_inputs = i_q_data.old_stable ^ (r_done | onehot);
        n_out.last_event    = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (can_load) begin
                r_out_valid <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* src/multi_input_debounce_events_unit.sv */
// multi-channel switch debouncer with event output
// input channel i_in_*: one poll per transfer, a timestamp in ms and the raw
// active-low pin levels; polls may arrive in back-to-back cycles
// output channel o_out_*: one event per transfer for each channel whose stable
// level changed, lowest channel first, last_event set on the final event of a poll;
// a poll that changes no stable bit gives no transfer
// config channel i_cfg_*: 16-bit debounce time in ms, always ready, reset value 30
// the first event of a poll is registered in the queue and then in the output
// register before it shows on o_out_valid
// throughput: the front takes one poll per cycle while the queue has room; the back
// emits one event per cycle unless the receiver stalls; a poll gives up to 4 events
// a 2-entry queue sits between the poll front end and the event serializer
// when the receiver stalls the output register holds, the queue fills and
// o_in_ready drops once it is full
// reset clears the previous levels, stable levels, change times, queue and
// output valid; the debounce time returns to 30
`default_nettype none
module multi_input_debounce_events_unit #(
    parameter int CHANNELS = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  msdb_pkg::t_in             i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output msdb_pkg::t_out            o_out_data,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire [msdb_pkg::DEB_W-1:0] i_cfg_data
);

    localparam int LANES = (CHANNELS < msdb_pkg::PIN_W) ? CHANNELS : msdb_pkg::PIN_W;
    localparam int RUN_W = $bits(msdb_pkg::t_run);

    logic [msdb_pkg::DEB_W-1:0] r_debounce;
    logic                       fq_valid;
    logic                       fq_ready;
    msdb_pkg::t_run             fq_data;
    logic                       qb_valid;
    logic                       qb_ready;
    logic [RUN_W-1:0]           qb_bits;
    msdb_pkg::t_run             qb_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= msdb_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce <= i_cfg_data;
        end
    end

    msdb_front #(
        .LANES(LANES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_debounce_time(r_debounce),
        .o_q_valid      (fq_valid),
        .i_q_ready      (fq_ready),
        .o_q_data       (fq_data)
    );

    msdb_fifo #(
        .WIDTH(RUN_W),
        .DEPTH(msdb_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(fq_valid),
        .o_ready(fq_ready),
        .i_data (fq_data),
        .o_valid(qb_valid),
        .i_ready(qb_ready),
        .o_data (qb_bits)
    );

    assign qb_data = msdb_pkg::t_run'(qb_bits);

    msdb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (qb_valid),
        .o_q_ready  (qb_ready),
        .i_q_data   (qb_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

class event_tracker;
    logic [3:0]     prev_levels;
    logic [3:0]     stable_mask;
    logic [31:0]    change_at [4];
    logic [15:0]    hold_ms;
    int             lanes;
    msdb_pkg::t_out pending_events [$];
    int             errors;
    int             polls;
    int             checked;

    function new(int channels);
        lanes = channels < 4 ? channels : 4;
        prev_levels = '0;
        stable_mask = '0;
        foreach (change_at[i]) change_at[i] = '0;
        hold_ms = msdb_pkg::DEBOUNCE_RESET;
        errors = 0;
        polls = 0;
        checked = 0;
    endfunction

    function void set_debounce(logic [15:0] ms);
        hold_ms = ms;
    endfunction

    function void note_poll(msdb_pkg::t_in p);
        msdb_pkg::t_out ev [4];
        logic [3:0]     seen;
        logic           level;
        int             n;
        seen = '0;
        n = 0;
        for (int i = 0; i < lanes; i++) begin
            level = ~p.pin_levels[i];
            seen[i] = level;
            if (level != prev_levels[i]) change_at[i] = p.now_time;
            if (p.now_time - change_at[i] >= {16'd0, hold_ms} && level != stable_mask[i]) begin
                stable_mask[i] = level;
                ev[n].channel = 2'(i);
                ev[n].new_level = level;
                ev[n].event_time = p.now_time;
                ev[n].stable_inputs = stable_mask;
                ev[n].last_event = 1'b0;
                n++;
            end
        end
        prev_levels = seen;
        for (int k = 0; k < n; k++) begin
            if (k == n - 1) ev[k].last_event = 1'b1;
            pending_events.push_back(ev[k]);
        end
        polls++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_event(msdb_pkg::t_out got);
        msdb_pkg::t_out want;
        if (pending_events.size() == 0) begin
            $display("%0t: event with none expected, got ch %0d level %b time %h mask %h last %b",
                     $time, got.channel, got.new_level, got.event_time, got.stable_inputs,
                     got.last_event);
            errors++;
            return;
        end
        want = pending_events.pop_front();
        checked++;
        compare_field("channel", want.channel, got.channel);
        compare_field("new_level", want.new_level, got.new_level);
        compare_field("event_time", want.event_time, got.event_time);
        compare_field("stable_inputs", want.stable_inputs, got.stable_inputs);
        compare_field("last_event", want.last_event, got.last_event);
    endfunction
endclass

module tb;
    localparam int CHANNELS    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS    = 8;
    localparam int SEG_POLLS   = 44;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    msdb_pkg::t_in              i_in_data = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    msdb_pkg::t_out             o_out_data;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [msdb_pkg::DEB_W-1:0] i_cfg_data = '0;

    event_tracker tracker;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           cycles = 0;
    logic [31:0]  cur_time = '0;
    logic [3:0]   cur_pins = 4'hF;
    logic [15:0]  deb_set [SEGMENTS] = '{16'd3, 16'd0, 16'hFFFF, 16'd0,
                                         16'd17, 16'd1, 16'd0, 16'd30};

    multi_input_debounce_events_unit #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tracker.set_debounce(i_cfg_data);
            if (i_in_valid && o_in_ready) tracker.note_poll(i_in_data);
            if (o_out_valid && i_out_ready) tracker.check_event(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_poll(input logic [31:0] t, input logic [3:0] pins);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data.now_time = t;
        i_in_data.pin_levels = pins;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_debounce(input logic [15:0] ms);
        i_cfg_valid = 1'b1;
        i_cfg_data = ms;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drain pending events, then cover polls still in flight that give no event
    task automatic settle();
        i_in_valid = 1'b0;
        while (tracker.pending_events.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // mostly held levels with small time steps, some bounces and time jumps
    task automatic random_poll();
        int          roll;
        logic [15:0] d;
        d = tracker.hold_ms;
        roll = $urandom_range(99, 0);
        if (roll < 5) cur_time = $urandom();
        else cur_time = cur_time + $urandom_range(d / 3 + 2, 0);
        roll = $urandom_range(99, 0);
        if (roll < 25) cur_pins = cur_pins ^ (4'b0001 << $urandom_range(3, 0));
        else if (roll < 40) cur_pins = 4'($urandom());
        send_poll(cur_time, cur_pins);
    endtask

    initial begin
        logic [15:0] d;
        tracker = new(CHANNELS);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_poll(32'd0, 4'hF);
        send_poll(32'd5, 4'h0);
        send_poll(32'd20, 4'h0);
        send_poll(32'd35, 4'h0);
        send_poll(32'd36, 4'hE);
        send_poll(32'd40, 4'hF);
        send_poll(32'd66, 4'hF);
        send_poll(32'd70, 4'hF);
        send_poll(32'd1000, 4'hA);
        send_poll(32'd10, 4'hA);
        send_poll(32'hFFFF_FFF0, 4'h5);
        send_poll(32'hFFFF_FFFF, 4'h5);
        send_poll(32'h0000_001D, 4'h5);
        settle();
        write_debounce(16'd0);
        send_poll(32'd100, 4'h7);
        send_poll(32'd100, 4'h8);
        settle();
        write_debounce(16'hFFFF);
        send_poll(32'd200, 4'hF);
        send_poll(32'd65734, 4'hF);
        send_poll(32'd65735, 4'hF);
        send_poll(32'hFFFF_FFFF, 4'h0);
        send_poll(32'd0, 4'h0);
        cur_time = 32'd0;
        cur_pins = 4'h0;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            case (seg % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 46;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 46;
                end
                default: begin
                    idle_pct = 9;
                    stall_pct = 9;
                end
            endcase
            d = deb_set[seg];
            if (seg == 3) d = 16'($urandom_range(200, 1));
            else if (seg == 6) d = 16'($urandom());
            write_debounce(d);
            if (seg % 3 == 0) cur_time = $urandom();
            repeat (SEG_POLLS) random_poll();
        end
        settle();

        $display("covered %0d polls and %0d events, debounce 0 to 65535, wrapping time,",
                 tracker.polls, tracker.checked);
        $display("sender gaps and receiver stalls alone, together and absent");
        if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
